### src/zcdc_pkg.sv
package zcdc_pkg;

  localparam int TOTAL_WIDTH = 48;
  localparam int HDR_LEN = 46;
  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_ENTRY_LIMIT = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_NAME_RANGE = 3'd3,
    ST_ENCRYPTED = 3'd4,
    ST_UNSAFE_PATH = 3'd5,
    ST_LINK = 3'd6,
    ST_EXPANSION = 3'd7
  } status_t;

  localparam logic [1:0] REG_EXPECTED = 2'd0;
  localparam logic [1:0] REG_MAX_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_directory;
  } in_word_t;

  typedef struct packed {
    logic        is_entry;
    logic [2:0]  status;
    logic [31:0] compressed_size;
    logic [31:0] expanded_size;
    logic        is_directory;
    logic [15:0] entry_number;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] expected_entries;
    logic [15:0] max_entry_count;
    logic [47:0] max_expanded_bytes;
  } cfg_t;

  // path checker state
  typedef struct packed {
    logic       bad;
    logic [1:0] comp;
    logic       alpha;
    logic [2:0] stem;
    logic       dot;
    logic       sep;
    logic [31:0] prefix;
  } path_t;

endpackage

### src/zcdc_path.sv
// One name character through the path-safety tracker, plus the final verdict.
module zcdc_path (
  input  zcdc_pkg::path_t    cur,
  input  logic [7:0]         c,
  input  logic               first,
  input  logic               second,
  output zcdc_pkg::path_t    nxt,
  input  zcdc_pkg::path_t    fin,
  input  logic [15:0]        nlen,
  output logic               unsafe
);
  import zcdc_pkg::*;

  logic sep, alpha;
  logic [7:0] u;
  logic [23:0] head;
  logic [7:0] dig;

  always_comb begin
    sep = (c == 8'h2f) || (c == 8'h5c);
    alpha = ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7a);
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    nxt = cur;
    if (first) begin
      if (sep) nxt.bad = 1'b1;
      if (alpha) nxt.alpha = 1'b1;
    end
    if (second && c == 8'h3a && cur.alpha) nxt.bad = 1'b1;
    if (sep) begin
      if (cur.comp == 2'd2) nxt.bad = 1'b1;
      nxt.comp = 2'd0;
      nxt.stem = 3'd0;
      nxt.dot = 1'b0;
      nxt.prefix = '0;
      nxt.sep = 1'b1;
    end else begin
      nxt.sep = 1'b0;
      if (c == 8'h2e) nxt.comp = (cur.comp < 2'd3) ? cur.comp + 2'd1 : 2'd3;
      else nxt.comp = 2'd3;
      if (!cur.dot) begin
        if (c == 8'h2e) nxt.dot = 1'b1;
        else begin
          case (cur.stem)
            3'd0: nxt.prefix[7:0] = cur.prefix[7:0] | u;
            3'd1: nxt.prefix[15:8] = cur.prefix[15:8] | u;
            3'd2: nxt.prefix[23:16] = cur.prefix[23:16] | u;
            3'd3: nxt.prefix[31:24] = cur.prefix[31:24] | u;
            default: ;
          endcase
          if (cur.stem < 3'd5) nxt.stem = cur.stem + 3'd1;
        end
      end
    end
  end

  always_comb begin
    head = fin.prefix[23:0];
    dig = fin.prefix[31:24];
    unsafe = (nlen == 16'd0) || fin.bad || (fin.comp == 2'd2);
    if (fin.stem == 3'd3 && (fin.prefix == 32'h004e4f43 || fin.prefix == 32'h004e5250 ||
        fin.prefix == 32'h00585541 || fin.prefix == 32'h004c554e)) unsafe = 1'b1;
    if (fin.stem == 3'd4 && (head == 24'h4d4f43 || head == 24'h54504c) &&
        dig >= 8'h31 && dig <= 8'h39) unsafe = 1'b1;
  end

endmodule

### src/zcdc_out_queue.sv
// Four-entry result queue; one byte may cause two words.
module zcdc_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  zcdc_pkg::out_word_t w0,
  input  zcdc_pkg::out_word_t w1,
  output logic                space2,
  output zcdc_pkg::out_word_t out_word,
  output logic                out_valid,
  input  logic                out_ready
);
  import zcdc_pkg::*;

  out_word_t q [4];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  logic pop;

  assign pop = out_valid && out_ready;
  assign out_valid = cnt != 3'd0;
  assign out_word = q[rd];
  assign space2 = cnt <= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wr <= '0;
      cnt <= '0;
    end else begin
      if (push_n != 2'd0) q[wr] <= w0;
      if (push_n == 2'd2) q[wr + 2'd1] <= w1;
      wr <= wr + push_n;
      if (pop) rd <= rd + 2'd1;
      cnt <= cnt + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

### src/zip_central_directory_checker_top.sv
// ZIP central directory checker.
// Input channel: one directory byte per word (data_byte, end_of_directory)
// on in_valid/in_ready. Output channel: result words on out_valid/out_ready;
// each byte causes zero, one or two words, the final one flagged by last.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 expected entries,
// 1 entry limit, 2 expanded-byte limit) and cfg_data; always ready.
// Throughput: one byte per cycle. All parsing for a byte is a single
// combinational pass from the state registers into a 4-word result queue,
// so a byte's result words are registered into the queue as it is accepted.
// in_ready drops only when the queue cannot take two more words, i.e.
// when the receiver stalls out_ready long enough to fill it.
// Reset (synchronous rst) clears the record position, captured header,
// counters, running size total, path tracker and the finished latch;
// config registers return to 0 / 65535 / 2^48-1.
// After an error or the final status the block latches: bytes are still
// taken but produce nothing until reset.
module zip_central_directory_checker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  zcdc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output zcdc_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import zcdc_pkg::*;

  cfg_t cfg;
  logic [17:0] pos;
  logic [63:0] hc0, hc1, hc2;
  logic [15:0] done_cnt;
  logic [TOTAL_WIDTH-1:0] total;
  path_t pf;
  logic latched;

  logic [17:0] pos_next;
  logic [63:0] hc0_next, hc1_next, hc2_next;
  logic [15:0] done_next;
  logic [TOTAL_WIDTH-1:0] total_next;
  path_t pf_next, pf_char;
  logic latched_next;
  logic [1:0] n;
  out_word_t w0, w1, wr, wf;
  logic space2, acc;

  logic [7:0] b;
  logic [15:0] nlen, nlen_c, xlen_c, clen_c;
  logic [18:0] rec_total, name_end;
  logic in_name, unsafe;
  logic [TOTAL_WIDTH:0] sum;
  logic [TOTAL_WIDTH-1:0] sat;
  logic [2:0] st;
  logic [47:0] max_lim;
  logic take;

  assign cfg_ready = 1'b1;
  assign in_ready = space2;
  assign acc = in_valid && in_ready;
  assign b = in_word.data_byte;
  assign nlen = hc0[63:48];
  assign in_name = (pos >= 18'(HDR_LEN)) && ({1'b0, pos} < name_end);
  assign name_end = 19'(HDR_LEN) + {3'b0, nlen};
  // byte is parsed only while entries remain and the count limit holds
  assign take = (cfg.expected_entries <= cfg.max_entry_count) &&
                (done_cnt < cfg.expected_entries);

  zcdc_path u_path (
    .cur(pf), .c(b), .first(pos == 18'(HDR_LEN)), .second(pos == 18'(HDR_LEN + 1)),
    .nxt(pf_char), .fin(pf_next), .nlen(nlen_c), .unsafe(unsafe)
  );

  always_comb begin
    hc0_next = hc0;
    hc1_next = hc1;
    hc2_next = hc2;
    pf_next = pf;
    case (pos)
      18'd0: hc0_next[7:0] = b;
      18'd1: hc0_next[15:8] = b;
      18'd2: hc0_next[23:16] = b;
      18'd3: hc0_next[31:24] = b;
      18'd8: hc0_next[39:32] = b;
      18'd9: hc0_next[47:40] = b;
      18'd20: hc1_next[7:0] = b;
      18'd21: hc1_next[15:8] = b;
      18'd22: hc1_next[23:16] = b;
      18'd23: hc1_next[31:24] = b;
      18'd24: hc1_next[39:32] = b;
      18'd25: hc1_next[47:40] = b;
      18'd26: hc1_next[55:48] = b;
      18'd27: hc1_next[63:56] = b;
      18'd28: hc0_next[55:48] = b;
      18'd29: hc0_next[63:56] = b;
      18'd30: hc2_next[7:0] = b;
      18'd31: hc2_next[15:8] = b;
      18'd32: hc2_next[23:16] = b;
      18'd33: hc2_next[31:24] = b;
      18'd38: hc2_next[39:32] = b;
      18'd39: hc2_next[47:40] = b;
      18'd40: hc2_next[55:48] = b;
      18'd41: hc2_next[63:56] = b;
      default: if (in_name) pf_next = pf_char;
    endcase
    nlen_c = hc0_next[63:48];
    xlen_c = hc2_next[15:0];
    clen_c = hc2_next[31:16];
    rec_total = 19'(HDR_LEN) + {3'b0, nlen_c} + {3'b0, xlen_c} + {3'b0, clen_c};
    sum = {1'b0, total} + {{(TOTAL_WIDTH-32){1'b0}}, 1'b0, hc1_next[63:32]};
    sat = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
    max_lim = cfg.max_expanded_bytes;
  end

  always_comb begin
    pos_next = pos;
    done_next = done_cnt;
    total_next = total;
    latched_next = latched;
    n = 2'd0;
    wr = '0;
    wf = '0;
    wr.entry_number = done_cnt;
    wf.entry_number = done_cnt;
    st = ST_OK;
    w0 = '0;
    w1 = '0;
    if (acc && !latched) begin
      if (cfg.expected_entries > cfg.max_entry_count) begin
        wr.status = ST_ENTRY_LIMIT;
        n = 2'd1;
        latched_next = 1'b1;
        wf = wr;
      end else begin
        if (done_cnt < cfg.expected_entries) begin
          if (pos == 18'd3 && hc0_next[31:0] != SIG_CENTRAL) begin
            wr.status = ST_MALFORMED;
            n = 2'd1;
            latched_next = 1'b1;
          end else if (pos >= 18'(HDR_LEN - 1) && ({1'b0, pos} + 19'd1 >= rec_total)) begin
            n = 2'd1;
            if (hc0_next[32]) st = ST_ENCRYPTED;
            else if (unsafe) st = ST_UNSAFE_PATH;
            else if (hc2_next[63:60] == 4'b1010) st = ST_LINK;
            else begin
              total_next = sat;
              if (64'(sat) > 64'(max_lim)) st = ST_EXPANSION;
            end
            wr.status = st;
            if (st != ST_OK) latched_next = 1'b1;
            else begin
              wr.is_entry = 1'b1;
              wr.compressed_size = hc1_next[31:0];
              wr.expanded_size = hc1_next[63:32];
              wr.is_directory = (nlen_c != 16'd0) && pf_next.sep;
              done_next = done_cnt + 16'd1;
            end
            pos_next = '0;
          end else pos_next = pos + 18'd1;
        end
        wf.entry_number = done_next;
        if (!latched_next && in_word.end_of_directory) begin
          if (done_next >= cfg.expected_entries) wf.status = ST_OK;
          else if (pos_next < 18'(HDR_LEN)) wf.status = ST_MALFORMED;
          else wf.status = ST_NAME_RANGE;
          latched_next = 1'b1;
          n = n + 2'd1;
        end
      end
      if (n == 2'd2) begin
        w0 = wr;
        w1 = wf;
        w1.last = 1'b1;
      end else if (n == 2'd1) begin
        w0 = (wr.status != ST_OK || wr.is_entry) && !(in_word.end_of_directory &&
             !wr.is_entry && wr.status == ST_OK) ? wr : wf;
        w0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_entries <= '0;
      cfg.max_entry_count <= 16'hffff;
      cfg.max_expanded_bytes <= '1;
      pos <= '0;
      hc0 <= '0;
      hc1 <= '0;
      hc2 <= '0;
      done_cnt <= '0;
      total <= '0;
      pf <= '0;
      latched <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_EXPECTED: cfg.expected_entries <= cfg_data[15:0];
          REG_MAX_COUNT: cfg.max_entry_count <= cfg_data[15:0];
          REG_MAX_BYTES: cfg.max_expanded_bytes <= cfg_data;
          default: ;
        endcase
      end
      if (acc && !latched) begin
        pos <= pos_next;
        done_cnt <= done_next;
        total <= total_next;
        latched <= latched_next;
        if (take) begin
          if (pos_next == '0 && pos != '0 || (pos_next == '0 && n != 2'd0)) begin
            hc0 <= '0;
            hc1 <= '0;
            hc2 <= '0;
            pf <= '0;
          end else begin
            hc0 <= hc0_next;
            hc1 <= hc1_next;
            hc2 <= hc2_next;
            pf <= pf_next;
          end
        end
      end
    end
  end

  zcdc_out_queue u_q (
    .clk(clk), .rst(rst), .push_n(n), .w0(w0), .w1(w1), .space2(space2),
    .out_word(out_word), .out_valid(out_valid), .out_ready(out_ready)
  );

endmodule

### src/zcdc_checker.sv
module zcdc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input zcdc_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input zcdc_pkg::out_word_t out_word
);
  import zcdc_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_word)) else $error("in hold");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word)) else $error("out hold");
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.is_entry |-> out_word.status == ST_OK) else $error("entry status");
  a_final_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.is_entry |-> out_word.compressed_size == 32'd0 &&
    out_word.expanded_size == 32'd0 && !out_word.is_directory) else $error("final fields");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");

endmodule

bind zip_central_directory_checker_top zcdc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

// Directory-stream testbench for the ZIP central directory checker.
// One reset, one stream: the block latches on its first error or final
// status, so the run feeds a long well-formed directory across several
// register settings and closes it with one randomly chosen ending.
module tb_top;
  import zcdc_pkg::*;

  localparam int QUIET_LIMIT = 4000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int SETTLE = 4;           // settle wait after drain; a result is registered as its byte is taken

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_EXPECTED;
  logic [47:0] cfg_data = '0;

  zip_central_directory_checker_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow copy of the checker: registers, record position, captured
  // header words, counters and the name tracker.
  // ---------------------------------------------------------------
  cfg_t regs_model;
  logic [17:0] rec_pos;
  logic [63:0] hdr_cap [3];
  logic [15:0] entries_seen;
  logic [TOTAL_WIDTH-1:0] size_total;
  path_t name_trk;
  bit halted;

  out_word_t expected_results[$];   // predicted words, oldest first
  out_word_t typed_entries[$];      // hand-written entry words from the table

  int mismatches = 0;
  int quiet = 0;
  int items_sent = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 82;
  bit hold_req = 1'b0;

  function automatic out_word_t mk(logic e, status_t st, logic [31:0] cs, logic [31:0] es,
                                   logic d, logic [15:0] n);
    out_word_t r;
    r.is_entry = e;
    r.status = st;
    r.compressed_size = cs;
    r.expanded_size = es;
    r.is_directory = d;
    r.entry_number = n;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] pk3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {8'h00, c, b, a};
  endfunction

  // One name character through the path tracker.
  task automatic take_name_char(input logic [17:0] p, input logic [7:0] c);
    path_t f;
    logic is_sep;
    logic is_alpha;
    logic [7:0] up;
    f = name_trk;
    is_sep = (c == "/") || (c == "\\");
    is_alpha = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
    if (p == HDR_LEN) begin
      if (is_sep) f.bad = 1'b1;
      if (is_alpha) f.alpha = 1'b1;
    end
    // drive letter: letter then colon
    if (p == HDR_LEN + 1 && c == ":" && f.alpha) f.bad = 1'b1;
    if (is_sep) begin
      if (f.comp == 2'd2) f.bad = 1'b1;   // ".." component closed
      f.comp = 2'd0;
      f.stem = 3'd0;
      f.dot = 1'b0;
      f.prefix = '0;
      f.sep = 1'b1;
    end else begin
      f.sep = 1'b0;
      if (c == ".") f.comp = (f.comp < 2'd3) ? f.comp + 2'd1 : 2'd3;
      else f.comp = 2'd3;
      if (!f.dot) begin
        if (c == ".") begin
          f.dot = 1'b1;
        end else begin
          up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
          if (f.stem < 3'd4) f.prefix[8*f.stem +: 8] = up;
          if (f.stem < 3'd5) f.stem = f.stem + 3'd1;
        end
      end
    end
    name_trk = f;
  endtask

  function automatic bit name_unsafe(logic [15:0] nlen);
    path_t f;
    f = name_trk;
    if (nlen == 0 || f.bad) return 1'b1;
    if (f.comp == 2'd2) return 1'b1;
    if (f.stem == 3'd3 && (f.prefix == pk3("C", "O", "N") || f.prefix == pk3("P", "R", "N") ||
        f.prefix == pk3("A", "U", "X") || f.prefix == pk3("N", "U", "L"))) return 1'b1;
    if (f.stem == 3'd4 && ({8'h00, f.prefix[23:0]} == pk3("C", "O", "M") ||
        {8'h00, f.prefix[23:0]} == pk3("L", "P", "T")) &&
        f.prefix[31:24] >= "1" && f.prefix[31:24] <= "9") return 1'b1;
    return 1'b0;
  endfunction

  // Record complete: checks in order, then entry or first error.
  task automatic end_record();
    logic [15:0] nlen;
    logic [31:0] es;
    logic [31:0] attrs;
    logic [TOTAL_WIDTH:0] sum;
    status_t st;
    nlen = hdr_cap[0][63:48];
    es = hdr_cap[1][63:32];
    attrs = hdr_cap[2][63:32];
    st = ST_OK;
    if (hdr_cap[0][32]) st = ST_ENCRYPTED;
    else if (name_unsafe(nlen)) st = ST_UNSAFE_PATH;
    else if (attrs[31:28] == 4'b1010) st = ST_LINK;
    else begin
      sum = {1'b0, size_total} + es;
      size_total = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
      if (size_total > regs_model.max_expanded_bytes) st = ST_EXPANSION;
    end
    if (st != ST_OK) begin
      expected_results = {expected_results, mk(1'b0, st, '0, '0, 1'b0, entries_seen)};
      halted = 1'b1;
    end else begin
      expected_results = {expected_results, mk(1'b1, ST_OK, hdr_cap[1][31:0], es,
                                               nlen != 0 && name_trk.sep, entries_seen)};
      entries_seen = entries_seen + 16'd1;
    end
    rec_pos = '0;
    foreach (hdr_cap[i]) hdr_cap[i] = '0;
    name_trk = '0;
  endtask

  task automatic consume_byte(input logic [7:0] b);
    int p;
    int nlen;
    int total;
    p = int'(rec_pos);
    nlen = int'(hdr_cap[0][63:48]);
    if (p < 4) hdr_cap[0][8*p +: 8] = b;
    else if (p == 8 || p == 9) hdr_cap[0][32 + 8*(p-8) +: 8] = b;
    else if (p >= 20 && p <= 23) hdr_cap[1][8*(p-20) +: 8] = b;
    else if (p >= 24 && p <= 27) hdr_cap[1][32 + 8*(p-24) +: 8] = b;
    else if (p == 28 || p == 29) hdr_cap[0][48 + 8*(p-28) +: 8] = b;
    else if (p == 30 || p == 31) hdr_cap[2][8*(p-30) +: 8] = b;
    else if (p == 32 || p == 33) hdr_cap[2][16 + 8*(p-32) +: 8] = b;
    else if (p >= 38 && p <= 41) hdr_cap[2][32 + 8*(p-38) +: 8] = b;
    else if (p >= HDR_LEN && p < HDR_LEN + nlen) take_name_char(p[17:0], b);
    if (p == 3 && hdr_cap[0][31:0] != SIG_CENTRAL) begin
      expected_results = {expected_results,
                          mk(1'b0, ST_MALFORMED, '0, '0, 1'b0, entries_seen)};
      halted = 1'b1;
      return;
    end
    if (p >= HDR_LEN - 1) begin
      total = HDR_LEN + int'(hdr_cap[0][63:48]) + int'(hdr_cap[2][15:0]) +
              int'(hdr_cap[2][31:16]);
      if (p + 1 >= total) begin
        end_record();
        return;
      end
    end
    rec_pos = 18'(p + 1);
  endtask

  // Expected words for one accepted byte; the final one carries last.
  task automatic predict_byte(input in_word_t w);
    int n_before;
    status_t st;
    if (halted) return;
    n_before = expected_results.size();
    if (regs_model.expected_entries > regs_model.max_entry_count) begin
      expected_results = {expected_results,
                          mk(1'b0, ST_ENTRY_LIMIT, '0, '0, 1'b0, entries_seen)};
      halted = 1'b1;
    end else begin
      if (entries_seen < regs_model.expected_entries) consume_byte(w.data_byte);
      if (!halted && w.end_of_directory) begin
        if (entries_seen >= regs_model.expected_entries) st = ST_OK;
        else st = (rec_pos < HDR_LEN) ? ST_MALFORMED : ST_NAME_RANGE;
        expected_results = {expected_results, mk(1'b0, st, '0, '0, 1'b0, entries_seen)};
        halted = 1'b1;
      end
    end
    if (expected_results.size() > n_before)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic field_check(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %0h got %0h", nm, e, a);
    end
  endtask

  task automatic compare_word(input out_word_t want, input out_word_t seen);
    field_check("is_entry", want.is_entry, seen.is_entry);
    field_check("status", want.status, seen.status);
    field_check("compressed_size", want.compressed_size, seen.compressed_size);
    field_check("expanded_size", want.expanded_size, seen.expanded_size);
    field_check("is_directory", want.is_directory, seen.is_directory);
    field_check("entry_number", want.entry_number, seen.entry_number);
    field_check("last", want.last, seen.last);
  endtask

  // ---------------------------------------------------------------
  // Monitor: all handshakes sampled at the rising edge, before the
  // block's own registers move.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t seen;
    out_word_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPECTED: regs_model.expected_entries = cfg_data[15:0];
          REG_MAX_COUNT: regs_model.max_entry_count = cfg_data[15:0];
          REG_MAX_BYTES: regs_model.max_expanded_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_byte(in_word);
      if (out_valid && out_ready) begin
        seen = out_word;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %0h", seen);
        end else begin
          want = expected_results.pop_front();
          compare_word(want, seen);
        end
        // hand-written entries from the directed table
        if (seen.is_entry && typed_entries.size() != 0 &&
            typed_entries[0].entry_number == seen.entry_number) begin
          want = typed_entries.pop_front();
          compare_word(want, seen);
        end
      end
      // watchdog: a hang shows up as a long run of cycles with no handshake
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------
  // Valid stays up across back-to-back words; it only drops in a gap.
  task automatic push_word(input logic [7:0] b, input bit eod);
    in_word <= '{data_byte: b, end_of_directory: eod};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pause: nothing offered until every expected word is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One record: 46-byte header, name, extra, comment. eod_at marks the
  // end of directory on that byte and stops the record there.
  task automatic send_record(input logic [7:0] nm[$], input logic [15:0] flg,
                             input logic [31:0] cs, input logic [31:0] es,
                             input logic [31:0] attrs, input int xlen, input int clen,
                             input bit sig_ok, input int eod_at);
    logic [7:0] rec[$];
    logic [7:0] rb;
    for (int i = 0; i < HDR_LEN; i++) begin
      rb = 8'($urandom);
      rec = {rec, rb};
    end
    rec[0] = 8'h50; rec[1] = 8'h4b; rec[2] = 8'h01; rec[3] = 8'h02;
    if (!sig_ok) rec[$urandom_range(0, 3)] ^= (8'h01 << $urandom_range(0, 7));
    rec[8] = flg[7:0]; rec[9] = flg[15:8];
    for (int i = 0; i < 4; i++) begin
      rec[20+i] = cs[8*i +: 8];
      rec[24+i] = es[8*i +: 8];
      rec[38+i] = attrs[8*i +: 8];
    end
    rec[28] = 8'(nm.size()); rec[29] = 8'(nm.size() >> 8);
    rec[30] = 8'(xlen); rec[31] = 8'(xlen >> 8);
    rec[32] = 8'(clen); rec[33] = 8'(clen >> 8);
    rec = {rec, nm};
    for (int i = 0; i < xlen + clen; i++) begin
      rb = 8'($urandom);
      rec = {rec, rb};
    end
    foreach (rec[i]) begin
      push_word(rec[i], i == eod_at);
      if (i == eod_at) break;
    end
  endtask

  function automatic int pick_len();
    return ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 5);
  endfunction

  // Safe names: no component starts with a dot or a device-name letter,
  // and no colon, so nothing trips the path checks.
  string first_chars = "bBdDeEfFgGhHiIjJkKmMoOqQrRsStTuUvVwWxXyYzZ0123456789_";
  string body_chars = "abcdefghijklmnopqrstuvwxyzACLNOPUX0123456789._-";

  task automatic make_name(output logic [7:0] nm[$]);
    int comps;
    logic [7:0] ch;
    nm = {};
    comps = $urandom_range(1, 3);
    for (int c = 0; c < comps; c++) begin
      if (c != 0) begin
        ch = $urandom_range(1) ? "/" : "\\";
        nm = {nm, ch};
      end
      ch = first_chars[$urandom_range(first_chars.len() - 1)];
      nm = {nm, ch};
      repeat ($urandom_range(0, 5)) begin
        ch = body_chars[$urandom_range(body_chars.len() - 1)];
        nm = {nm, ch};
      end
    end
    if ($urandom_range(5) == 0) begin
      ch = $urandom_range(1) ? "/" : "\\";
      nm = {nm, ch};
    end
  endtask

  task automatic random_record(input logic [15:0] flg_or, input bit sig_ok, input int eod_at);
    logic [7:0] nm[$];
    logic [31:0] attrs;
    logic [15:0] flg;
    make_name(nm);
    attrs = $urandom;
    if (attrs[31:28] == 4'b1010) attrs[28] = 1'b1;
    flg = (16'($urandom) & 16'hfffe) | flg_or;
    send_record(nm, flg, $urandom, $urandom, attrs, pick_len(), pick_len(), sig_ok, eod_at);
  endtask

  task automatic random_phase(input int goal);
    int start;
    int recs;
    start = items_sent;
    recs = 0;
    while (items_sent - start < goal || recs < 2) begin
      random_record(16'h0000, 1'b1, -1);
      recs++;
    end
  endtask

  // Directed records; typed rows carry their entry word by hand.
  typedef struct {
    string nm;
    logic [15:0] flg;
    logic [31:0] cs;
    logic [31:0] es;
    logic [31:0] attrs;
    int xlen;
    int clen;
    bit typed;
    bit dir;
  } dir_row_t;

  dir_row_t dir_rows [15] = '{
    '{"a",         16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 1, 0},
    '{"dir/",      16'hfffe, 32'hffff_ffff, 32'hffff_ffff, 32'hbfff_ffff, 0, 0, 1, 1},
    '{"x\\",       16'h0002, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 0, 0, 1, 1},
    '{"COM10.txt", 16'h0008, 32'h1234_5678, 32'h0000_1000, 32'h81a4_0000, 0, 0, 0, 0},
    '{"LPT0",      16'h0000, 32'h0000_0010, 32'h0000_0020, 32'h0000_0000, 0, 0, 0, 0},
    '{"CONS",      16'h0000, 32'h0000_0011, 32'h0000_0021, 32'h0000_0000, 0, 0, 0, 0},
    '{"con.d/b",   16'h0800, 32'h0000_0012, 32'h0000_0022, 32'h0000_0000, 0, 0, 0, 0},
    '{"a.b.c",     16'h0000, 32'h0000_0013, 32'h0000_0023, 32'h0000_0000, 0, 0, 0, 0},
    '{"..a",       16'h0000, 32'h0000_0014, 32'h0000_0024, 32'h0000_0000, 0, 0, 0, 0},
    '{"...",       16'h0000, 32'h0000_0015, 32'h0000_0025, 32'h0000_0000, 0, 0, 0, 0},
    '{"1:y",       16'h0000, 32'h0000_0016, 32'h0000_0026, 32'h0000_0000, 0, 0, 0, 0},
    '{"a/CON/b",   16'h0000, 32'h0000_0017, 32'h0000_0027, 32'h0000_0000, 0, 0, 0, 0},
    '{"AUX.txt/",  16'h0000, 32'h0000_0018, 32'h0000_0028, 32'h0000_0000, 0, 0, 1, 1},
    '{"e",         16'h0000, 32'h0000_0019, 32'h0000_0029, 32'h7fff_ffff, 3, 2, 0, 0},
    '{"Z",         16'h0000, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 0, 0, 1, 0}
  };

  string bad_names [8] = '{"", "/etc", "\\x", "c:x", "a/../b", "CON.txt", "lpt3", "Com7.dat"};

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    logic [7:0] nm[$];
    logic [31:0] attrs;
    logic [7:0] rb;
    logic [7:0] ch;
    out_word_t typed_w;
    int kind;
    int body_end;
    regs_model = '{expected_entries: 16'd0, max_entry_count: 16'hffff,
                   max_expanded_bytes: '1};
    rec_pos = '0;
    foreach (hdr_cap[i]) hdr_cap[i] = '0;
    entries_seen = '0;
    size_total = '0;
    name_trk = '0;
    halted = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, all registers at their extremes
    write_reg(REG_EXPECTED, 48'hffff);
    write_reg(REG_MAX_COUNT, 48'hffff);
    write_reg(REG_MAX_BYTES, 48'hffff_ffff_ffff);
    end_writes();
    foreach (dir_rows[r]) begin
      nm = {};
      for (int i = 0; i < dir_rows[r].nm.len(); i++) begin
        ch = dir_rows[r].nm[i];
        nm = {nm, ch};
      end
      if (dir_rows[r].typed) begin
        typed_w = mk(1'b1, ST_OK, dir_rows[r].cs, dir_rows[r].es, dir_rows[r].dir, 16'(r));
        typed_w.last = 1'b1;
        typed_entries = {typed_entries, typed_w};
      end
      send_record(nm, dir_rows[r].flg, dir_rows[r].cs, dir_rows[r].es, dir_rows[r].attrs,
                  dir_rows[r].xlen, dir_rows[r].clen, 1'b1, -1);
    end

    // random phase 1: count limit equal to the expected count;
    // the receiver holds off long enough to back up the input
    drain();
    write_reg(REG_EXPECTED, 48'd1000);
    write_reg(REG_MAX_COUNT, 48'd1000);
    write_reg(REG_MAX_BYTES, size_total + 48'h0100_0000_0000);
    end_writes();
    hold_req = 1'b1;
    random_phase(200);

    // random phase 2: idling swapped
    drain();
    tx_idle_pct = 82;
    rx_idle_pct = 13;
    write_reg(REG_EXPECTED, 48'd30000);
    write_reg(REG_MAX_COUNT, 48'd40000);
    write_reg(REG_MAX_BYTES, 48'hffff_ffff_ffff);
    end_writes();
    random_phase(100);

    // random phase 3: no idling on either side
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_MAX_BYTES, size_total + 48'h0100_0000_0000);
    end_writes();
    random_phase(100);

    // one closing event per run; the block latches after it
    drain();
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin  // record completes on the end marker
        write_reg(REG_EXPECTED, entries_seen + 48'd1);
        end_writes();
        make_name(nm);
        body_end = HDR_LEN + nm.size() - 1;
        send_record(nm, 16'h0000, $urandom, $urandom, 32'h0, 0, 0, 1'b1, body_end);
      end
      1: begin  // surplus bytes after the last entry, then end marker
        write_reg(REG_EXPECTED, 48'(entries_seen));
        end_writes();
        repeat ($urandom_range(1, 12)) begin
          rb = 8'($urandom);
          push_word(rb, 1'b0);
        end
        rb = 8'($urandom);
        push_word(rb, 1'b1);
      end
      2: begin  // expected count above the limit
        write_reg(REG_MAX_COUNT, 48'd0);
        end_writes();
        rb = 8'($urandom);
        push_word(rb, 1'b0);
      end
      3: random_record(16'h0000, 1'b0, -1);
      4: random_record(16'h0001, 1'b1, -1);
      5: begin
        nm = {};
        kind = $urandom_range(0, 7);
        for (int i = 0; i < bad_names[kind].len(); i++) begin
          ch = bad_names[kind][i];
          nm = {nm, ch};
        end
        send_record(nm, 16'h0000, $urandom, $urandom, 32'h0, pick_len(), 0, 1'b1, -1);
      end
      6: begin
        make_name(nm);
        attrs = {4'b1010, 28'($urandom)};
        send_record(nm, 16'h0000, $urandom, $urandom, attrs, 0, 0, 1'b1, -1);
      end
      7: begin  // running total pushed just past its limit
        write_reg(REG_MAX_BYTES, size_total);
        end_writes();
        make_name(nm);
        send_record(nm, 16'h0000, $urandom, $urandom | 32'h1, 32'h0, 0, 0, 1'b1, -1);
      end
      8: random_record(16'h0000, 1'b1, $urandom_range(0, HDR_LEN - 2));
      default: begin  // stream ends from the last header byte to the extra byte
        make_name(nm);
        body_end = HDR_LEN + nm.size() + 2;
        send_record(nm, 16'h0000, $urandom, $urandom, 32'h0, 1, 1'b1 ? 1 : 0, 1'b1,
                    $urandom_range(HDR_LEN - 1, body_end - 2));
      end
    endcase

    // latched now: these bytes must produce nothing
    repeat (20) begin
      rb = 8'($urandom);
      push_word(rb, $urandom_range(1));
    end

    drain();
    repeat (10) @(posedge clk);
    mismatches += expected_results.size() + typed_entries.size();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
